// ===== hw/rtl/reversible_char_sequence_editor_unit_macros.svh =====
// Assertion macros for the sequence editor RTL.
`ifndef REVERSIBLE_CHAR_SEQUENCE_EDITOR_UNIT_MACROS_SVH
`define REVERSIBLE_CHAR_SEQUENCE_EDITOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define RCSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define RCSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCSE_ASSERT_IMP(lbl, ante, cons, msg)
`define RCSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/rcse_pkg.sv =====
// Package with widths, command codes and cell select codes for the sequence editor.
package rcse_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 7;

  // Command codes carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT       = 3'd0,
    CMD_INSERT_FRONT = 3'd1,
    CMD_INSERT_BACK  = 3'd2,
    CMD_DELETE       = 3'd3,
    CMD_DELETE_FRONT = 3'd4,
    CMD_DELETE_BACK  = 3'd5,
    CMD_REVERSE      = 3'd6,
    CMD_PRINT        = 3'd7
  } cmd_e;

  // Next-value source of one storage cell
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LOAD  = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } cell_sel_e;

endpackage

// ===== hw/rtl/rcse_cell.sv =====
// One character cell of the storage ring: holds, loads, or takes a neighbor's byte.
module rcse_cell
  import rcse_pkg::*;
(
  input  logic              clk_i,
  input  cell_sel_e         sel_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic [CHAR_W-1:0] left_i,
  input  logic [CHAR_W-1:0] right_i,
  output logic [CHAR_W-1:0] data_o
);

  logic [CHAR_W-1:0] data_q;

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (sel_i)
      SEL_HOLD:  data_q <= data_q;
      SEL_LOAD:  data_q <= char_i;
      SEL_LEFT:  data_q <= left_i;
      SEL_RIGHT: data_q <= right_i;
    endcase
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/reversible_char_sequence_editor_unit.sv =====
// Top level of the reversible character sequence editor: command decode, print sequencer, cell ring.
//
// Usage:
//   Commands arrive on the slave stream: tuser carries the command code, tdata the
//   character (bits 7:0) and the logical position (bits 14:8). Printed characters
//   leave on the master stream: tdata is the character, tlast marks the final one
//   of a print run and tuser flags a print of an empty sequence.
//   Edits (insert, delete at any end or position) and reverse complete in the cycle
//   they are accepted: every cell of the ring shifts toward or away from the edit
//   point at once, so one edit is taken per cycle while no print runs.
//   A print rotates the whole ring of MAX_LEN cells once, one step per cycle while
//   the receiver does not stall, and emits a character whenever the wanted one sits
//   at the ring's end cell.
//   No command is accepted while a print runs. A stalled receiver freezes the
//   rotation only in cycles that must emit; the output register lets the next
//   command in while the last result still waits.
//   Reset empties the sequence and sets normal order; the cells are not cleared.
`include "reversible_char_sequence_editor_unit_macros.svh"

module reversible_char_sequence_editor_unit
  import rcse_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,   // char_in[7:0], position[14:8], zero[15]
  input  logic [CMD_W-1:0]    s_axis_tuser_i,   // cmd[2:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [CHAR_W-1:0]   m_axis_tdata_o,   // char_out[7:0]
  output logic                m_axis_tlast_o,   // last_char
  output logic                m_axis_tuser_o    // is_empty[0]
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q;
  logic [LW-1:0]      len_q;
  logic               rev_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;
  logic               out_empty_q;

  logic [CHAR_W-1:0]  cell_data [MAX_LEN];
  cell_sel_e          cell_sel  [MAX_LEN];

  logic               in_acc;
  cmd_e               cmd;
  logic [CHAR_W-1:0]  char_in;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   len_ext;
  logic [POS_W-1:0]   phys;
  logic               full;
  logic               seq_empty;
  logic               ins_ok;
  logic               del_ok;
  logic               do_ins;
  logic               do_del;

  logic               printing;
  logic [LW-1:0]      cnt_ext;
  logic               emit;
  logic               emit_last;
  logic               can_push;
  logic               advance;
  logic               out_load;
  logic [CHAR_W-1:0]  tap_char;

  // Input transaction fields
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign char_in = s_axis_tdata_i[7:0];
  assign pos     = s_axis_tdata_i[14:8];
  assign len_ext = POS_W'(len_q);

  assign full      = (len_q == LW'(MAX_LEN));
  assign seq_empty = (len_q == '0);

  // Command decode: legality and physical edit point
  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    phys   = '0;
    unique case (cmd)
      CMD_INSERT: begin
        ins_ok = !full && (pos <= len_ext);
        phys   = rev_q ? (len_ext - pos) : pos;
      end
      CMD_INSERT_FRONT: begin
        ins_ok = !full;
        phys   = rev_q ? len_ext : '0;
      end
      CMD_INSERT_BACK: begin
        ins_ok = !full;
        phys   = rev_q ? '0 : len_ext;
      end
      CMD_DELETE: begin
        del_ok = (pos < len_ext);
        phys   = rev_q ? (len_ext - POS_W'(1) - pos) : pos;
      end
      CMD_DELETE_FRONT: begin
        del_ok = !seq_empty;
        phys   = rev_q ? (len_ext - POS_W'(1)) : '0;
      end
      CMD_DELETE_BACK: begin
        del_ok = !seq_empty;
        phys   = rev_q ? '0 : (len_ext - POS_W'(1));
      end
      CMD_REVERSE, CMD_PRINT: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  assign do_ins = in_acc && ins_ok;
  assign do_del = in_acc && del_ok;

  // Print sequencer: ring rotates left (normal) or right (reversed)
  assign printing  = (state_q == ST_PRINT);
  assign cnt_ext   = LW'(cnt_q);
  assign emit      = rev_q ? (cnt_ext >= (LW'(MAX_LEN) - len_q)) : (cnt_ext < len_q);
  assign emit_last = rev_q ? (cnt_q == CW'(MAX_LEN - 1)) : (cnt_ext == (len_q - LW'(1)));
  assign can_push  = !out_valid_q || m_axis_tready_i;
  assign advance   = printing && !seq_empty && (!emit || can_push);
  assign out_load  = printing && (seq_empty ? can_push : (advance && emit));
  assign tap_char  = rev_q ? cell_data[MAX_LEN-1] : cell_data[0];

  // Cell ring with per-cell select
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    localparam int unsigned LEFT_IDX  = (k == 0) ? MAX_LEN - 1 : k - 1;
    localparam int unsigned RIGHT_IDX = (k == MAX_LEN - 1) ? 0 : k + 1;

    always_comb begin
      cell_sel[k] = SEL_HOLD;
      priority if (advance) begin
        cell_sel[k] = rev_q ? SEL_LEFT : SEL_RIGHT;
      end else if (do_ins) begin
        if (POS_W'(k) == phys) begin
          cell_sel[k] = SEL_LOAD;
        end else if (POS_W'(k) > phys) begin
          cell_sel[k] = SEL_LEFT;
        end
      end else if (do_del) begin
        if (POS_W'(k) >= phys) begin
          cell_sel[k] = SEL_RIGHT;
        end
      end
    end

    rcse_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel[k]),
      .char_i  (char_in),
      .left_i  (cell_data[LEFT_IDX]),
      .right_i (cell_data[RIGHT_IDX]),
      .data_o  (cell_data[k])
    );
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      // Output register: load a printed character or drain on ready
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_char_q  <= seq_empty ? '0 : tap_char;
        out_last_q  <= seq_empty ? 1'b1 : emit_last;
        out_empty_q <= seq_empty;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (do_ins) begin
            len_q <= len_q + LW'(1);
          end
          if (do_del) begin
            len_q <= len_q - LW'(1);
          end
          if (in_acc && (cmd == CMD_REVERSE)) begin
            rev_q <= !rev_q;
          end
          if (in_acc && (cmd == CMD_PRINT)) begin
            state_q <= ST_PRINT;
            cnt_q   <= '0;
          end
        end
        ST_PRINT: begin
          if (seq_empty) begin
            if (can_push) begin
              state_q <= ST_IDLE;
            end
          end else if (advance) begin
            if (cnt_q == CW'(MAX_LEN - 1)) begin
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_empty_q;

  // Checks
  `RCSE_ASSERT_IMP(a_len_max, 1'b1, len_q <= LW'(MAX_LEN), "length above capacity")
  `RCSE_ASSERT_NXT(a_ins_grows, do_ins, len_q == $past(len_q) + LW'(1), "insert lost")
  `RCSE_ASSERT_NXT(a_rev_toggle, in_acc && (cmd == CMD_REVERSE), rev_q != $past(rev_q), "reverse lost")
  `RCSE_ASSERT_NXT(a_print_keeps_len, printing, len_q == $past(len_q), "length moved in print")
  `RCSE_ASSERT_IMP(a_empty_is_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o, "empty not last")

endmodule

// ===== test/reversible_char_sequence_editor_unit_test.sv =====
// Self-checking testbench for the reversible character sequence editor unit.
`timescale 1ns / 100ps

module reversible_char_sequence_editor_unit_test;
  import rcse_pkg::*;

  localparam int unsigned SEQ_DEPTH   = 64;
  localparam int unsigned IDLE_PCT    = 13;
  localparam int unsigned DRAIN_WAIT  = SEQ_DEPTH + 16;

  // One printed character as the editor should emit it
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
  } printed_char_t;

  // Tracks the character sequence and the printed characters still owed
  class char_seq_scoreboard;
    logic [CHAR_W-1:0] chars [SEQ_DEPTH];
    int unsigned       len;
    bit                flipped;
    printed_char_t     owed [$];
    int unsigned       errors;

    function new();
      len     = 0;
      flipped = 1'b0;
      errors  = 0;
    endfunction

    // Open a gap at physical index phys and drop the character in
    function void place(int unsigned phys, logic [CHAR_W-1:0] c);
      if (len >= SEQ_DEPTH || phys > len) return;
      for (int unsigned k = len; k > phys; k--) chars[k] = chars[k-1];
      chars[phys] = c;
      len++;
    endfunction

    // Close the gap left by the character at physical index phys
    function void remove(int unsigned phys);
      if (phys >= len) return;
      for (int unsigned k = phys; k + 1 < len; k++) chars[k] = chars[k+1];
      len--;
    endfunction

    // Apply one accepted command transaction
    function void note_command(cmd_e cmd, logic [CHAR_W-1:0] c, logic [POS_W-1:0] pos);
      printed_char_t item;
      int unsigned   p;
      p = 32'(pos);
      case (cmd)
        CMD_INSERT: begin
          if (p <= len) place(flipped ? len - p : p, c);
        end
        CMD_INSERT_FRONT: place(flipped ? len : 0, c);
        CMD_INSERT_BACK:  place(flipped ? 0 : len, c);
        CMD_DELETE: begin
          if (p < len) remove(flipped ? len - 1 - p : p);
        end
        CMD_DELETE_FRONT: begin
          if (len > 0) remove(flipped ? len - 1 : 0);
        end
        CMD_DELETE_BACK: begin
          if (len > 0) remove(flipped ? 0 : len - 1);
        end
        CMD_REVERSE: flipped = !flipped;
        default: begin
          if (len == 0) begin
            item = '{ch: '0, last: 1'b1, empty: 1'b1};
            owed = {owed, item};
          end else begin
            for (int unsigned k = 0; k < len; k++) begin
              item = '{ch: chars[flipped ? len - 1 - k : k], last: (k + 1 == len),
                       empty: 1'b0};
              owed = {owed, item};
            end
          end
        end
      endcase
    endfunction

    // Compare one output transaction with the oldest owed character
    function void check_result(logic [CHAR_W-1:0] c, logic last, logic empty);
      printed_char_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: char_out %0h last_char %0b is_empty %0b", c, last, empty);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (c !== want.ch) begin
        $error("char_out mismatch: expected %0h, actual %0h", want.ch, c);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (empty !== want.empty) begin
        $error("is_empty mismatch: expected %0b, actual %0b", want.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;
  logic [CMD_W-1:0]  s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CHAR_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  // Both sides stop idling while set
  bit calm;

  char_seq_scoreboard sb;

  reversible_char_sequence_editor_unit #(
    .MAX_LEN(SEQ_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast),
    .m_axis_tuser_o (m_axis_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // Send one command transaction and record it once accepted
  task automatic push_command(cmd_e cmd, logic [CHAR_W-1:0] c, logic [POS_W-1:0] pos);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, pos, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, c, pos);
  endtask

  // Insert with a random flavor; mostly legal positions
  task automatic random_insert();
    cmd_e        cmd;
    int unsigned pos;
    case ($urandom_range(2))
      0:       cmd = CMD_INSERT;
      1:       cmd = CMD_INSERT_FRONT;
      default: cmd = CMD_INSERT_BACK;
    endcase
    pos = ($urandom_range(99) < 85) ? $urandom_range(sb.len) : $urandom_range(SEQ_DEPTH);
    push_command(cmd, CHAR_W'($urandom_range(255)), POS_W'(pos));
  endtask

  // Delete with a random flavor; mostly legal positions
  task automatic random_delete();
    cmd_e        cmd;
    int unsigned pos;
    case ($urandom_range(2))
      0:       cmd = CMD_DELETE;
      1:       cmd = CMD_DELETE_FRONT;
      default: cmd = CMD_DELETE_BACK;
    endcase
    if ($urandom_range(99) < 85 && sb.len > 0) pos = $urandom_range(sb.len - 1);
    else pos = $urandom_range(SEQ_DEPTH);
    push_command(cmd, CHAR_W'($urandom_range(255)), POS_W'(pos));
  endtask

  // Mixed traffic; grow_pct steers the balance of inserts against deletes
  task automatic run_burst(int unsigned count, int unsigned grow_pct);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 8)
        push_command(CMD_PRINT, CHAR_W'($urandom_range(255)),
                     POS_W'($urandom_range(SEQ_DEPTH)));
      else if (roll < 13)
        push_command(CMD_REVERSE, CHAR_W'($urandom_range(255)),
                     POS_W'($urandom_range(SEQ_DEPTH)));
      else if ($urandom_range(99) < grow_pct) random_insert();
      else random_delete();
    end
  endtask

  // Grow to full, push on the full sequence, then shrink to empty and beyond
  task automatic fill_and_drain();
    while (sb.len < SEQ_DEPTH) begin
      if ($urandom_range(99) < 4) push_command(CMD_REVERSE, CHAR_W'($urandom_range(255)), 0);
      else random_insert();
    end
    push_command(CMD_INSERT, CHAR_W'($urandom_range(255)), POS_W'(SEQ_DEPTH));
    push_command(CMD_INSERT_FRONT, CHAR_W'($urandom_range(255)), 0);
    push_command(CMD_INSERT_BACK, CHAR_W'($urandom_range(255)), 0);
    push_command(CMD_PRINT, 8'h00, 0);
    while (sb.len > 0) begin
      if ($urandom_range(99) < 5) push_command(CMD_PRINT, CHAR_W'($urandom_range(255)), 0);
      else random_delete();
    end
    push_command(CMD_DELETE_BACK, 8'h00, 0);
    push_command(CMD_PRINT, 8'h00, 0);
  endtask

  // Hang guard
  initial begin
    #5_000_000;
    $display("FAIL reversible_char_sequence_editor_unit");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    sb            = new();
    calm          = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_INSERT;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty sequence corner cases
    push_command(CMD_PRINT, 8'h00, 0);
    push_command(CMD_DELETE_FRONT, 8'h00, 0);
    push_command(CMD_DELETE_BACK, 8'h00, 0);
    push_command(CMD_DELETE, 8'h00, 0);
    push_command(CMD_INSERT, 8'h11, 1);
    // Directed: build a short sequence in normal order
    push_command(CMD_INSERT, 8'h00, 0);
    push_command(CMD_INSERT_BACK, 8'hFF, 0);
    push_command(CMD_INSERT_FRONT, 8'hA5, 0);
    push_command(CMD_INSERT, 8'h5A, 3);
    push_command(CMD_INSERT, 8'h3C, 1);
    push_command(CMD_PRINT, 8'h00, 0);
    // Directed: edits in reversed order, out of range delete
    push_command(CMD_REVERSE, 8'h00, 0);
    push_command(CMD_PRINT, 8'h00, 0);
    push_command(CMD_INSERT, 8'h81, 0);
    push_command(CMD_INSERT_BACK, 8'h7E, 0);
    push_command(CMD_INSERT_FRONT, 8'h42, 0);
    push_command(CMD_DELETE, 8'h00, 2);
    push_command(CMD_DELETE, 8'h00, 64);
    push_command(CMD_DELETE_FRONT, 8'h00, 0);
    push_command(CMD_DELETE_BACK, 8'h00, 0);
    push_command(CMD_PRINT, 8'h00, 0);
    push_command(CMD_REVERSE, 8'h00, 0);
    push_command(CMD_PRINT, 8'h00, 0);

    // Random: bursts of growth, shrinkage and balance, plus full/empty sweeps
    run_burst(60, 75);
    run_burst(40, 50);
    calm = 1'b1;
    fill_and_drain();
    calm = 1'b0;
    run_burst(50, 65);
    run_burst(40, 30);
    fill_and_drain();
    run_burst(40, 50);
    s_axis_tvalid <= 1'b0;

    // Let owed characters come out, then watch for strays
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.owed.size() != 0) begin
      $error("%0d printed characters never arrived", sb.owed.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS reversible_char_sequence_editor_unit");
    end else begin
      $display("FAIL reversible_char_sequence_editor_unit");
    end
    $finish;
  end

endmodule
